@@ sv/bzs_pkg.sv @@
// bzs_pkg: shared types and constants for the cubic Bezier split pipeline.
// No dependencies; imported by bzs_lerp_lvl, cubic_bezier_split and tb_cubic_bezier_split.
`timescale 1ns / 1ps
`default_nettype none

package bzs_pkg;

  // Register stages of the whole pipeline: two per lerp level, three levels.
  localparam int PIPE_STAGES = 6;

  // Axes of a point and lerp lanes per axis at each De Casteljau level.
  localparam int NUM_AXES  = 2;
  localparam int L1_LANES  = 3;
  localparam int L2_LANES  = 2;
  localparam int L3_LANES  = 1;

  // Load enables for the two register stages of one lerp level.
  typedef struct packed {
    logic load_mul;
    logic load_add;
  } bzs_ctl_t;

endpackage

`default_nettype wire

@@ sv/bzs_lerp_lvl.sv @@
// bzs_lerp_lvl: one De Casteljau level, a row of fixed-point lerp lanes.
// Two register stages: difference times t, then shift and add. Uses bzs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bzs_lerp_lvl #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16,
  parameter int LANES      = 2
) (
  input  logic                         clk,
  input  bzs_pkg::bzs_ctl_t            ctl,
  input  logic [FRAC_BITS:0]           t,
  input  logic signed [COORD_BITS-1:0] a [LANES],
  input  logic signed [COORD_BITS-1:0] b [LANES],
  output logic signed [COORD_BITS-1:0] y [LANES]
);
  import bzs_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int TW = FRAC_BITS + 2;
  localparam int PW = DW + TW;

  logic signed [DW-1:0]         diff  [LANES];
  logic signed [TW-1:0]         ts;
  logic signed [PW-1:0]         prod  [LANES];
  logic signed [COORD_BITS-1:0] a_q   [LANES];
  logic signed [PW-1:0]         shf   [LANES];

  assign ts = signed'({1'b0, t});

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      diff[i] = DW'(b[i]) - DW'(a[i]);
      shf[i]  = prod[i] >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_mul) begin
      for (int i = 0; i < LANES; i++) begin
        prod[i] <= PW'(diff[i]) * PW'(ts);
        a_q[i]  <= a[i];
      end
    end
    // the lerp stays between its ends, so the sum fits modulo 2^COORD_BITS
    if (ctl.load_add) begin
      for (int i = 0; i < LANES; i++) begin
        y[i] <= a_q[i] + signed'(shf[i][COORD_BITS-1:0]);
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/cubic_bezier_split.sv @@
// cubic_bezier_split: splits a cubic Bezier or line segment at t by De Casteljau.
// Depends on bzs_pkg and bzs_lerp_lvl (three instances, one per level).
//
//  channel  dir  tdata                                     tuser
//  s_axis   in   P0..P3 x/y, split_param                   curve_mode
//  m_axis   out  new_start_ctrl, split_in_ctrl, split,     valid_res
//                split_out_ctrl, new_end_ctrl (x, y each)
//
// Pipeline: six register stages, two per lerp level (multiply, then shift/add);
//   one transfer in and one out per cycle when not stalled.
// Reset: rst clears only the stage valid bits; the data path has no reset.
// Stalls: each stage holds while full and blocked downstream; bubbles collapse,
//   so input keeps flowing into empty stages while a result waits at the output.
`timescale 1ns / 1ps
`default_nettype none

module cubic_bezier_split #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // start_x, start_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, end_x, end_y,
  // split_param, zero fill to whole bytes
  input  logic [((8*COORD_BITS+FRAC_BITS+1+7)/8)*8-1:0] s_axis_tdata,
  // curve_mode
  input  logic [0:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // new_start_ctrl_x/y, split_in_ctrl_x/y, split_x/y, split_out_ctrl_x/y,
  // new_end_ctrl_x/y, zero fill to whole bytes
  output logic [((10*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  // valid_res
  output logic [0:0] m_axis_tuser
);
  import bzs_pkg::*;

  localparam int CW     = COORD_BITS;
  localparam int TW     = FRAC_BITS + 1;
  localparam int OUT_W  = 10 * CW;
  localparam int N1     = NUM_AXES * L1_LANES;
  localparam int N2     = NUM_AXES * L2_LANES;
  localparam int N3     = NUM_AXES * L3_LANES;
  localparam logic [TW-1:0] T_ONE = TW'(1) << FRAC_BITS;

  // ---------------------------------------------------------------- control
  logic [PIPE_STAGES-1:0] vld;
  logic [PIPE_STAGES-1:0] adv;

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    adv[PIPE_STAGES-1] = !vld[PIPE_STAGES-1] || m_axis_tready;
    for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < PIPE_STAGES; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = vld[PIPE_STAGES-1];

  // ------------------------------------------------------------ input unpack
  logic signed [CW-1:0] p [4][NUM_AXES];
  logic [TW-1:0]        t_in;
  logic                 curve_in;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        p[k][ax] = signed'(s_axis_tdata[(2*k+ax)*CW +: CW]);
      end
    end
  end

  assign t_in     = s_axis_tdata[8*CW +: TW];
  assign curve_in = s_axis_tuser[0];

  // ------------------------------------------------------- sideband stages
  // t is needed at the entry of each level; curve and range flag ride to the end.
  logic [TW-1:0] t_q     [4];
  logic          curve_q [PIPE_STAGES];
  logic          ok_q    [PIPE_STAGES];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      t_q[0]     <= t_in;
      curve_q[0] <= curve_in;
      ok_q[0]    <= (t_in <= T_ONE);
    end
    for (int i = 1; i < PIPE_STAGES; i++) begin
      if (adv[i]) begin
        curve_q[i] <= curve_q[i-1];
        ok_q[i]    <= ok_q[i-1];
      end
    end
    for (int i = 1; i < 4; i++) begin
      if (adv[i]) begin
        t_q[i] <= t_q[i-1];
      end
    end
  end

  // ------------------------------------------------------------- level one
  // Lanes per axis: P0-P1 (P0-P3 in line mode), P1-P2, P2-P3.
  logic signed [CW-1:0] l1_a [N1];
  logic signed [CW-1:0] l1_b [N1];
  logic signed [CW-1:0] l1_y [N1];
  bzs_ctl_t             l1_ctl;

  always_comb begin
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      l1_a[ax*L1_LANES+0] = p[0][ax];
      l1_b[ax*L1_LANES+0] = curve_in ? p[1][ax] : p[3][ax];
      l1_a[ax*L1_LANES+1] = p[1][ax];
      l1_b[ax*L1_LANES+1] = p[2][ax];
      l1_a[ax*L1_LANES+2] = p[2][ax];
      l1_b[ax*L1_LANES+2] = p[3][ax];
    end
  end

  assign l1_ctl = '{load_mul: adv[0], load_add: adv[1]};

  bzs_lerp_lvl #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .LANES     (N1)
  ) u_lvl1 (
    .clk(clk),
    .ctl(l1_ctl),
    .t  (t_in),
    .a  (l1_a),
    .b  (l1_b),
    .y  (l1_y)
  );

  // ------------------------------------------------------------- level two
  logic signed [CW-1:0] l2_a [N2];
  logic signed [CW-1:0] l2_b [N2];
  logic signed [CW-1:0] l2_y [N2];
  bzs_ctl_t             l2_ctl;

  always_comb begin
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      l2_a[ax*L2_LANES+0] = l1_y[ax*L1_LANES+0];
      l2_b[ax*L2_LANES+0] = l1_y[ax*L1_LANES+1];
      l2_a[ax*L2_LANES+1] = l1_y[ax*L1_LANES+1];
      l2_b[ax*L2_LANES+1] = l1_y[ax*L1_LANES+2];
    end
  end

  assign l2_ctl = '{load_mul: adv[2], load_add: adv[3]};

  bzs_lerp_lvl #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .LANES     (N2)
  ) u_lvl2 (
    .clk(clk),
    .ctl(l2_ctl),
    .t  (t_q[1]),
    .a  (l2_a),
    .b  (l2_b),
    .y  (l2_y)
  );

  // Carry the outer first-level points (or the line split point) to the end.
  // Index ax*2 holds the start-side point, ax*2+1 the end-side point.
  logic signed [CW-1:0] outer_q [2:PIPE_STAGES-1][N2];

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        outer_q[2][ax*2+0] <= l1_y[ax*L1_LANES+0];
        outer_q[2][ax*2+1] <= l1_y[ax*L1_LANES+2];
      end
    end
    for (int s = 3; s < PIPE_STAGES; s++) begin
      if (adv[s]) begin
        outer_q[s] <= outer_q[s-1];
      end
    end
  end

  // ----------------------------------------------------------- level three
  logic signed [CW-1:0] l3_a [N3];
  logic signed [CW-1:0] l3_b [N3];
  logic signed [CW-1:0] l3_y [N3];
  bzs_ctl_t             l3_ctl;

  always_comb begin
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      l3_a[ax] = l2_y[ax*L2_LANES+0];
      l3_b[ax] = l2_y[ax*L2_LANES+1];
    end
  end

  assign l3_ctl = '{load_mul: adv[4], load_add: adv[5]};

  bzs_lerp_lvl #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .LANES     (N3)
  ) u_lvl3 (
    .clk(clk),
    .ctl(l3_ctl),
    .t  (t_q[3]),
    .a  (l3_a),
    .b  (l3_b),
    .y  (l3_y)
  );

  // Carry the second-level points (split controls) alongside level three.
  logic signed [CW-1:0] mid_q [4:PIPE_STAGES-1][N2];

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      mid_q[4] <= l2_y;
    end
    if (adv[5]) begin
      mid_q[5] <= mid_q[4];
    end
  end

  // --------------------------------------------------------------- output
  // Zero every field for t above one; zero the controls in line mode, where
  // the split point comes straight from level one.
  logic ok_out;
  logic ctrl_en;

  assign ok_out  = ok_q[PIPE_STAGES-1];
  assign ctrl_en = ok_out && curve_q[PIPE_STAGES-1];

  always_comb begin
    m_axis_tdata = '0;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      m_axis_tdata[(0+ax)*CW +: CW] = ctrl_en ? outer_q[5][ax*2+0] : '0;
      m_axis_tdata[(2+ax)*CW +: CW] = ctrl_en ? mid_q[5][ax*2+0]   : '0;
      m_axis_tdata[(4+ax)*CW +: CW] = !ok_out ? '0 :
                                      (ctrl_en ? l3_y[ax] : outer_q[5][ax*2+0]);
      m_axis_tdata[(6+ax)*CW +: CW] = ctrl_en ? mid_q[5][ax*2+1]   : '0;
      m_axis_tdata[(8+ax)*CW +: CW] = ctrl_en ? outer_q[5][ax*2+1] : '0;
    end
  end

  assign m_axis_tuser[0] = ok_out;

  // ------------------------------------------------------------ assertions
  // An empty output stage must let the whole pipeline move.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !vld[PIPE_STAGES-1] |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  // A full pipeline blocked at the output must refuse new transfers.
  a_full_block: assert property (@(posedge clk) disable iff (rst)
    (&vld && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken into a full, stalled pipeline");

  // Out-of-range t produces an all-zero result.
  a_bad_t_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[OUT_W-1:0] == '0))
    else $error("nonzero result for t above one");

  // Line mode carries no control points.
  a_line_ctrl: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !curve_q[PIPE_STAGES-1]) |->
      (m_axis_tdata[4*CW-1:0] == '0 && m_axis_tdata[OUT_W-1:6*CW] == '0))
    else $error("control output nonzero in line mode");

endmodule

`default_nettype wire

@@ tb/sv/tb_cubic_bezier_split.sv @@
// tb_cubic_bezier_split: self-checking bench for the cubic Bezier split pipeline.
// Depends on bzs_pkg and cubic_bezier_split; predicts every split in fixed point and
// compares each output transfer field by field under random stalls on both sides.
`timescale 1ns / 1ps

module tb_cubic_bezier_split;
  import bzs_pkg::*;

  localparam int CW          = 32;                        // coordinate width
  localparam int FB          = 16;                        // fraction bits
  localparam int TW          = FB + 1;                    // split_param width
  localparam int S_W         = ((8 * CW + TW + 7) / 8) * 8;
  localparam int O_W         = ((10 * CW + 7) / 8) * 8;
  localparam int RAND_ITEMS  = 450;
  localparam int RX_HOLD     = 60;                        // long receiver hold-off
  localparam int CYCLE_LIMIT = 50000;

  localparam logic [CW-1:0] C_MIN = {1'b1, {(CW - 1){1'b0}}};
  localparam logic [CW-1:0] C_MAX = {1'b0, {(CW - 1){1'b1}}};
  localparam logic [TW-1:0] T_ONE = TW'(1) << FB;         // 1.0
  localparam logic [TW-1:0] T_TOP = {TW{1'b1}};           // largest out-of-range t

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [S_W-1:0]   s_axis_tdata  = '0;
  logic [0:0]       s_axis_tuser  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [O_W-1:0]   m_axis_tdata;
  logic [0:0]       m_axis_tuser;

  bit calm = 1'b0;          // suppress idling on both sides
  int hold_asks = 0;        // bump to request a receiver hold-off

  cubic_bezier_split #(
    .COORD_BITS(CW),
    .FRAC_BITS (FB)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Scoreboard: predicts the De Casteljau split of each accepted segment and
  // matches output transfers against the oldest pending prediction.
  class split_board;
    logic [O_W:0] pending_splits[$];   // {valid_res, packed result}
    int           miss_count = 0;

    // a + floor(t * (b - a) / 2^FB); the product fits easily in 64 bits
    function longint lerp_q(longint a, longint b, longint t);
      return a + ((t * (b - a)) >>> FB);
    endfunction

    function string field_name(int k);
      case (k)
        0: return "new_start_ctrl_x";
        1: return "new_start_ctrl_y";
        2: return "split_in_ctrl_x";
        3: return "split_in_ctrl_y";
        4: return "split_x";
        5: return "split_y";
        6: return "split_out_ctrl_x";
        7: return "split_out_ctrl_y";
        8: return "new_end_ctrl_x";
        default: return "new_end_ctrl_y";
      endcase
    endfunction

    function void note_miss(string what, logic [CW-1:0] want, logic [CW-1:0] got);
      miss_count++;
      if (miss_count <= 10)
        $display("%0t mismatch %s: expected %h, got %h", $time, what, want, got);
    endfunction

    // Record one accepted segment and queue its predicted split.
    function void note_segment(logic [S_W-1:0] d, logic curve);
      longint       p[8];
      longint       t, a1, b1, c1, a2, b2, sp;
      logic [O_W:0] split;
      int           k, ax;
      split = '0;
      t = longint'(d[8 * CW +: TW]);
      if (t <= longint'(T_ONE)) begin
        split[O_W] = 1'b1;
        for (k = 0; k < 8; k++)
          p[k] = longint'($signed(d[k * CW +: CW]));
        for (ax = 0; ax < 2; ax++) begin
          if (curve) begin
            a1 = lerp_q(p[ax], p[2 + ax], t);
            b1 = lerp_q(p[2 + ax], p[4 + ax], t);
            c1 = lerp_q(p[4 + ax], p[6 + ax], t);
            a2 = lerp_q(a1, b1, t);
            b2 = lerp_q(b1, c1, t);
            sp = lerp_q(a2, b2, t);
            split[(0 + ax) * CW +: CW] = a1[CW-1:0];
            split[(2 + ax) * CW +: CW] = a2[CW-1:0];
            split[(4 + ax) * CW +: CW] = sp[CW-1:0];
            split[(6 + ax) * CW +: CW] = b2[CW-1:0];
            split[(8 + ax) * CW +: CW] = c1[CW-1:0];
          end else begin
            // line mode: only the split point, controls stay zero
            sp = lerp_q(p[ax], p[6 + ax], t);
            split[(4 + ax) * CW +: CW] = sp[CW-1:0];
          end
        end
      end
      pending_splits = {pending_splits, split};
    endfunction

    // Compare one output transfer with the oldest prediction.
    function void check_split(logic [O_W-1:0] d, logic vld);
      logic [O_W:0] want;
      int           k;
      if (pending_splits.size() == 0) begin
        note_miss("unexpected result", '0, d[CW-1:0]);
        return;
      end
      want = pending_splits.pop_front();
      if (want[O_W] !== vld)
        note_miss("valid_res", CW'(want[O_W]), CW'(vld));
      for (k = 0; k < 10; k++)
        if (want[k * CW +: CW] !== d[k * CW +: CW])
          note_miss(field_name(k), want[k * CW +: CW], d[k * CW +: CW]);
    endfunction

    function int pending();
      return pending_splits.size();
    endfunction

    function int failures();
      return miss_count + pending_splits.size();
    endfunction
  endclass

  split_board board;

  // 2 ns clock
  initial begin
    forever #1 clk = ~clk;
  end

  // Pack one segment into the input tdata layout, first field lowest.
  function automatic logic [S_W-1:0] seg_bits(input logic [CW-1:0] sx, sy, ax, ay,
                                              bx, by, ex, ey, input logic [TW-1:0] t);
    return {{(S_W - 8 * CW - TW){1'b0}}, t, ey, ex, by, bx, ay, ax, sy, sx};
  endfunction

  // Mix rails, small values near zero and full-range noise.
  function automatic logic [CW-1:0] pick_coord();
    case ($urandom_range(9))
      0: return C_MIN;
      1: return C_MAX;
      2: return '0;
      3, 4, 5: return CW'($urandom_range(0, 1 << 21) - (1 << 20));
      default: return CW'($urandom);
    endcase
  endfunction

  // Mostly valid t, with both end points and the invalid range well covered.
  function automatic logic [TW-1:0] pick_split_param();
    case ($urandom_range(9))
      0: return '0;
      1: return T_ONE;
      2: return TW'($urandom_range(T_ONE + 1, T_TOP));
      default: return TW'($urandom_range(0, T_ONE - 1));
    endcase
  endfunction

  function automatic logic [S_W-1:0] random_segment();
    return seg_bits(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                    pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                    pick_split_param());
  endfunction

  // Offer one segment, idle at random before it, hold until the transfer.
  task automatic send_segment(input logic [S_W-1:0] bits, input logic curve);
    while (!calm && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= bits;
    s_axis_tuser  <= curve;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_segment(bits, curve);
  endtask

  // Drop valid and wait until every queued split has come out.
  task automatic drain_splits();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic run_directed();
    // all zero, then rails at t = 1.0, 0 and 0.5
    send_segment(seg_bits(0, 0, 0, 0, 0, 0, 0, 0, TW'(0)), 1'b1);
    send_segment(seg_bits(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, T_ONE), 1'b1);
    send_segment(seg_bits(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, TW'(0)),
                 1'b1);
    send_segment(seg_bits(C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX,
                          T_ONE >> 1), 1'b1);
    // line mode: controls carry junk that must be ignored
    send_segment(seg_bits(C_MIN, C_MAX, 123, 456, 789, 1011, C_MAX, C_MIN, T_ONE >> 1), 1'b0);
    send_segment(seg_bits(C_MIN, C_MAX, 123, 456, 789, 1011, C_MAX, C_MIN, TW'(0)), 1'b0);
    send_segment(seg_bits(C_MIN, C_MAX, 123, 456, 789, 1011, C_MAX, C_MIN, T_ONE), 1'b0);
    // t just above 1.0 and at the top of its range, both modes
    send_segment(seg_bits(5, 6, 7, 8, 9, 10, 11, 12, T_ONE + TW'(1)), 1'b1);
    send_segment(seg_bits(5, 6, 7, 8, 9, 10, 11, 12, T_ONE + TW'(1)), 1'b0);
    send_segment(seg_bits(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, T_TOP), 1'b1);
    send_segment(seg_bits(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, T_TOP), 1'b0);
    // smallest and largest fractional steps across the full span
    send_segment(seg_bits(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, TW'(1)),
                 1'b1);
    send_segment(seg_bits(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX,
                          T_ONE - TW'(1)), 1'b1);
    // alternating bit patterns
    send_segment(seg_bits(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555,
                          32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555,
                          17'h0aaaa), 1'b1);
    send_segment(seg_bits(32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555, 32'haaaa_aaaa,
                          32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555, 32'haaaa_aaaa,
                          17'h15555), 1'b1);
    // floor rounding of tiny negative steps
    send_segment(seg_bits(0, 0, -1, -1, 1, 1, -3, 3, TW'(1)), 1'b1);
    send_segment(seg_bits(0, 0, -1, -1, 1, 1, -3, 3, T_ONE - TW'(1)), 1'b1);
    send_segment(seg_bits(0, 0, 9, 9, 9, 9, -1, -7, TW'(3)), 1'b0);
    // inactive controls sit on their anchors
    send_segment(seg_bits(32'h0001_8000, -32'sd70000, 32'h0001_8000, -32'sd70000,
                          32'hfff0_0000, 32'h0020_0000, 32'hfff0_0000, 32'h0020_0000,
                          17'h04000), 1'b1);
  endtask

  // Output monitor: check every transfer at the edge that completes it.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_split(m_axis_tdata, m_axis_tuser[0]);
  end

  // Receiver: random backpressure, plus a long counted hold-off on request.
  initial begin : rx_side
    int hold_done;
    int hold_cycles;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_done) begin
        hold_done = hold_asks;
        for (hold_cycles = 0; hold_cycles < RX_HOLD; hold_cycles++) begin
          m_axis_tready <= 1'b0;
          @(posedge clk);
        end
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 23);
    end
  end

  // Watchdog: end the run if it stalls.
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Main sequence: reset, directed segments, random segments, drain, verdict.
  initial begin : main_seq
    int n;
    board = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    for (n = 0; n < RAND_ITEMS; n++) begin
      calm = (n >= 40 && n < 140);   // long stretch with no idling at all
      if (n == 220)
        hold_asks++;                 // receiver stops while segments keep coming
      if (n == 330)
        drain_splits();              // pause the sender until the pipe is empty
      send_segment(random_segment(), $urandom_range(3) != 0);
    end
    calm = 1'b0;

    drain_splits();
    // leave room for any stray output after the last expected one
    repeat (2 * PIPE_STAGES) @(posedge clk);
    if (board.failures() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
